// ----- hw/rtl/shb_pkg.sv -----
// Shared types, constants and command codes of the SHA-1 byte hasher.
// Depends on nothing; every other file of the block imports it.
package shb_pkg;

   // Request operation codes.
   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_BYTE   = 2'd1;
   localparam logic [1:0] OP_FINISH = 2'd2;

   localparam int DigestWords = 5;

   // Initial hash values.
   localparam logic [31:0] INIT_HASH [DigestWords] = '{
      32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
   };

   // Round constants, one for each group of twenty rounds.
   localparam logic [31:0] K_0 = 32'h5A827999;
   localparam logic [31:0] K_1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_3 = 32'hCA62C1D6;

   localparam logic [7:0] PAD_BYTE = 8'h80;

   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic        status;
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last;
   } rsp_type;

   // Classified command handed from the front end to the hash core.
   typedef enum logic [1:0] {
      CMD_START,
      CMD_BYTE,
      CMD_FINISH,
      CMD_BAD
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [7:0]   data;
   } cmd_type;

endpackage

// ----- hw/rtl/shb_front.sv -----
// Front end of the SHA-1 byte hasher: classifies request items and holds
// them in a two-entry command queue for the hash core. Uses shb_pkg.
module shb_front import shb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    cmd_valid,
   output cmd_type cmd,
   input  logic    cmd_pop
);

   cmd_type    q_ff [2];
   logic       wr_ff;
   logic       rd_ff;
   logic [1:0] cnt_ff;
   cmd_type    cls_in;
   logic       push_ok;
   logic       pop_ok;

   // Map the operation code onto a command kind.
   always_comb begin
      cls_in.data = req_data.data_byte;
      case (req_data.op)
         OP_START:  cls_in.kind = CMD_START;
         OP_BYTE:   cls_in.kind = CMD_BYTE;
         OP_FINISH: cls_in.kind = CMD_FINISH;
         default:   cls_in.kind = CMD_BAD;
      endcase
   end

   assign req_full  = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rd_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_pop && cmd_valid;

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ff] <= cls_in;
      end
   end

   // Queue pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (push_ok) begin
            wr_ff <= ~wr_ff;
         end
         if (pop_ok) begin
            rd_ff <= ~rd_ff;
         end
         if (push_ok && !pop_ok) begin
            cnt_ff <= cnt_ff + 2'd1;
         end else if (pop_ok && !push_ok) begin
            cnt_ff <= cnt_ff - 2'd1;
         end
      end
   end

endmodule

// ----- hw/rtl/shb_core.sv -----
// Hash core of the SHA-1 byte hasher: block buffer, padding sequencer,
// one round per cycle compression and result register. Uses shb_pkg.
module shb_core import shb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd,
   output logic    cmd_pop,
   output logic    rsp_empty,
   output rsp_type rsp_data,
   input  logic    rsp_pop
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_PAD,
      S_ROUND,
      S_ADD,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      RET_EMIT,
      RET_PAD,
      RET_DIGEST
   } ret_type;

   state_type    state_ff;
   ret_type      ret_ff;
   logic [6:0]   rnd_ff;
   logic [5:0]   idx_ff;
   logic [63:0]  len_ff;
   logic         comp_ff;
   logic         corr_ff;
   logic [31:0]  h_ff [DigestWords];
   logic [31:0]  wv_ff [DigestWords];
   logic [511:0] blk_ff;
   logic         first_ff;
   logic         lenph_ff;
   logic         dig_ff;
   logic         st_ff;
   logic [2:0]   cnt_ff;
   logic         rsp_valid_ff;
   rsp_type      rsp_ff;

   logic [63:0]  len_in;
   logic [31:0]  f_in;
   logic [31:0]  k_in;
   logic [31:0]  tmp_in;
   logic [31:0]  sched_in;
   logic [31:0]  x_in;
   logic         slot_free;

   assign len_in    = len_ff + 64'd8;
   assign slot_free = !rsp_valid_ff || rsp_pop;
   assign cmd_pop   = (state_ff == S_IDLE) && cmd_valid;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Round function and round constant by round group.
   always_comb begin
      if (rnd_ff < 7'd20) begin
         f_in = (wv_ff[1] & wv_ff[2]) | (~wv_ff[1] & wv_ff[3]);
         k_in = K_0;
      end else if (rnd_ff < 7'd40) begin
         f_in = wv_ff[1] ^ wv_ff[2] ^ wv_ff[3];
         k_in = K_1;
      end else if (rnd_ff < 7'd60) begin
         f_in = (wv_ff[1] & wv_ff[2]) | (wv_ff[1] & wv_ff[3]) | (wv_ff[2] & wv_ff[3]);
         k_in = K_2;
      end else begin
         f_in = wv_ff[1] ^ wv_ff[2] ^ wv_ff[3];
         k_in = K_3;
      end
      tmp_in = {wv_ff[0][26:0], wv_ff[0][31:27]} + f_in + wv_ff[4]
               + blk_ff[511:480] + k_in;
      // The block buffer doubles as the message schedule window.
      x_in     = blk_ff[95:64] ^ blk_ff[255:224] ^ blk_ff[447:416] ^ blk_ff[511:480];
      sched_in = {x_in[30:0], x_in[31]};
   end

   // Sequencer, state, and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= 6'd0;
         len_ff       <= 64'd0;
         comp_ff      <= 1'b0;
         corr_ff      <= 1'b0;
         for (int i = 0; i < DigestWords; i++) begin
            h_ff[i] <= INIT_HASH[i];
         end
      end else begin
         // A new item fills the result slot; otherwise a pop empties it.
         if (state_ff == S_EMIT && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_pop && rsp_valid_ff) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  dig_ff   <= 1'b0;
                  st_ff    <= 1'b1;
                  cnt_ff   <= 3'd0;
                  state_ff <= S_EMIT;
                  case (cmd.kind)
                     CMD_START: begin
                        for (int i = 0; i < DigestWords; i++) begin
                           h_ff[i] <= INIT_HASH[i];
                        end
                        idx_ff  <= 6'd0;
                        len_ff  <= 64'd0;
                        comp_ff <= 1'b0;
                        corr_ff <= 1'b0;
                        st_ff   <= 1'b0;
                     end
                     CMD_BYTE: begin
                        if (comp_ff) begin
                           corr_ff <= 1'b1;
                        end else if (!corr_ff) begin
                           st_ff  <= 1'b0;
                           blk_ff <= {blk_ff[503:0], cmd.data};
                           idx_ff <= idx_ff + 6'd1;
                           len_ff <= len_in;
                           if (len_in == 64'd0) begin
                              corr_ff <= 1'b1;
                           end
                           if (idx_ff == 6'd63) begin
                              ret_ff   <= RET_EMIT;
                              rnd_ff   <= 7'd0;
                              wv_ff    <= h_ff;
                              state_ff <= S_ROUND;
                           end
                        end
                     end
                     CMD_FINISH: begin
                        if (!corr_ff) begin
                           if (comp_ff) begin
                              dig_ff <= 1'b1;
                              st_ff  <= 1'b0;
                           end else begin
                              first_ff <= 1'b1;
                              lenph_ff <= 1'b0;
                              state_ff <= S_PAD;
                           end
                        end
                     end
                     default: begin
                        st_ff <= 1'b1;
                     end
                  endcase
               end
            end
            S_PAD: begin
               // One padding byte per cycle, none at the step into the length: marker, zeros, then the length.
               if (!first_ff && !lenph_ff && idx_ff == 6'd56) begin
                  lenph_ff <= 1'b1;
               end else begin
                  first_ff <= 1'b0;
                  idx_ff   <= idx_ff + 6'd1;
                  if (first_ff) begin
                     blk_ff <= {blk_ff[503:0], PAD_BYTE};
                  end else if (lenph_ff) begin
                     blk_ff <= {blk_ff[503:0], len_ff[63:56]};
                     len_ff <= {len_ff[55:0], 8'd0};
                  end else begin
                     blk_ff <= {blk_ff[503:0], 8'd0};
                  end
                  if (idx_ff == 6'd63) begin
                     ret_ff   <= (lenph_ff && !first_ff) ? RET_DIGEST : RET_PAD;
                     rnd_ff   <= 7'd0;
                     wv_ff    <= h_ff;
                     state_ff <= S_ROUND;
                  end
               end
            end
            S_ROUND: begin
               wv_ff[4] <= wv_ff[3];
               wv_ff[3] <= wv_ff[2];
               wv_ff[2] <= {wv_ff[1][1:0], wv_ff[1][31:2]};
               wv_ff[1] <= wv_ff[0];
               wv_ff[0] <= tmp_in;
               blk_ff   <= {blk_ff[479:0], sched_in};
               rnd_ff   <= rnd_ff + 7'd1;
               if (rnd_ff == 7'd79) begin
                  state_ff <= S_ADD;
               end
            end
            S_ADD: begin
               for (int i = 0; i < DigestWords; i++) begin
                  h_ff[i] <= h_ff[i] + wv_ff[i];
               end
               case (ret_ff)
                  RET_PAD: begin
                     state_ff <= S_PAD;
                  end
                  RET_DIGEST: begin
                     comp_ff  <= 1'b1;
                     dig_ff   <= 1'b1;
                     st_ff    <= 1'b0;
                     cnt_ff   <= 3'd0;
                     state_ff <= S_EMIT;
                  end
                  default: begin
                     state_ff <= S_EMIT;
                  end
               endcase
            end
            S_EMIT: begin
               if (slot_free) begin
                  if (dig_ff) begin
                     rsp_ff.status      <= 1'b0;
                     rsp_ff.digest_word <= h_ff[cnt_ff];
                     rsp_ff.word_index  <= cnt_ff;
                     rsp_ff.last        <= (cnt_ff == 3'd4);
                  end else begin
                     rsp_ff.status      <= st_ff;
                     rsp_ff.digest_word <= 32'd0;
                     rsp_ff.word_index  <= 3'd0;
                     rsp_ff.last        <= 1'b1;
                  end
                  if (!dig_ff || cnt_ff == 3'd4) begin
                     state_ff <= S_IDLE;
                  end else begin
                     cnt_ff <= cnt_ff + 3'd1;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // The round counter stays within the eighty rounds of a block.
   a_round_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_ROUND |-> rnd_ff < 7'd80)
      else $error("round counter out of range");

   // Only digest words may be followed by further items of the same input.
   a_nonlast_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ff.last |-> !rsp_ff.status)
      else $error("error item not marked last");

   // The fifth digest word closes the group.
   a_last_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.word_index == 3'd4 |-> rsp_ff.last)
      else $error("final digest word not marked last");

   // A waiting result is never overwritten before it is taken.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_pop |=> $stable(rsp_ff))
      else $error("result overwritten while waiting");

endmodule

// ----- hw/rtl/sha1_byte_hasher.sv -----
// Top level of the SHA-1 byte hasher: front end queue and hash core.
// Depends on shb_pkg, shb_front and shb_core.
//
//   Channel  Ports                          Direction
//   request  req_push, req_data, req_full   in  (op, data_byte)
//   result   rsp_pop, rsp_data, rsp_empty   out (status, word, index, last)
//
// A start, an error or a byte that does not fill a block passes the idle
// and emit states of the core; the 64th byte of a block adds the eighty
// rounds and the final add. A first finish pads one byte per cycle, none
// as the length begins, runs one or two compressions, then gives five
// items, one per cycle while the result register is free. Reset is
// synchronous and restores the initial hash state. A two-entry queue lets
// requests arrive while the core works or the result register waits.
module sha1_byte_hasher import shb_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    req_full,
   output logic    rsp_empty,
   output rsp_type rsp_data,
   input  logic    rsp_pop
);

   logic    cmd_valid;
   cmd_type cmd;
   logic    cmd_pop;

   // Classification and command queue.
   shb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop)
   );

   // Hashing and results.
   shb_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data),
      .rsp_pop   (rsp_pop)
   );

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench of the SHA-1 byte hasher: directed table, boundary lengths, then random messages.
// Depends on shb_pkg and the sha1_byte_hasher RTL.
`timescale 1ns / 100ps

module tb_top;
   import shb_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   req_type req_data = '0;
   logic    req_full;
   logic    rsp_empty;
   rsp_type rsp_data;
   logic    rsp_pop = 1'b0;

   sha1_byte_hasher uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_data(req_data), .req_full(req_full),
      .rsp_empty(rsp_empty), .rsp_data(rsp_data), .rsp_pop(rsp_pop)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted hasher state.
   logic [31:0] hash_state [5];
   logic [7:0]  msg_block [64];
   int unsigned fill_count;
   logic [63:0] msg_bits;
   logic        done_flag;
   logic        bad_flag;

   rsp_type digest_queue [$];
   bit      failed = 1'b0;
   bit      quiet_tail = 1'b0;
   int      idle_cycles = 0;
   int      items_sent = 0;

   function automatic logic [31:0] rotl32(logic [31:0] w, int n);
      return (w << n) | (w >> (32 - n));
   endfunction

   // Eighty rounds over the current block, then the chaining add.
   task automatic compress_block();
      logic [31:0] w [16];
      logic [31:0] a, b, c, d, e, f, k, tmp;
      int s;
      for (int t = 0; t < 16; t++)
         w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
      a = hash_state[0]; b = hash_state[1]; c = hash_state[2];
      d = hash_state[3]; e = hash_state[4];
      for (int t = 0; t < 80; t++) begin
         s = t & 15;
         if (t >= 16)
            w[s] = rotl32(w[(s+13)&15] ^ w[(s+8)&15] ^ w[(s+2)&15] ^ w[s], 1);
         if (t < 20) begin
            f = (b & c) | (~b & d); k = K_0;
         end else if (t < 40) begin
            f = b ^ c ^ d; k = K_1;
         end else if (t < 60) begin
            f = (b & c) | (b & d) | (c & d); k = K_2;
         end else begin
            f = b ^ c ^ d; k = K_3;
         end
         tmp = rotl32(a, 5) + f + e + w[s] + k;
         e = d; d = c; c = rotl32(b, 30); b = a; a = tmp;
      end
      hash_state[0] += a; hash_state[1] += b; hash_state[2] += c;
      hash_state[3] += d; hash_state[4] += e;
      fill_count = 0;
   endtask

   task automatic restart_message();
      for (int i = 0; i < 5; i++) hash_state[i] = INIT_HASH[i];
      fill_count = 0;
      msg_bits = '0;
      done_flag = 1'b0;
      bad_flag = 1'b0;
   endtask

   task automatic push_single(logic st);
      rsp_type r;
      r = '0;
      r.status = st;
      r.last = 1'b1;
      digest_queue.push_back(r);
   endtask

   // Work out the results of one accepted item.
   task automatic predict_hasher(req_type rq);
      rsp_type r;
      if (rq.op == OP_START) begin
         restart_message();
         push_single(1'b0);
      end else if (rq.op == OP_BYTE) begin
         if (done_flag) begin
            bad_flag = 1'b1;
            push_single(1'b1);
         end else if (bad_flag) begin
            push_single(1'b1);
         end else begin
            msg_block[fill_count & 63] = rq.data_byte;
            fill_count++;
            msg_bits += 64'd8;
            if (msg_bits == 0) bad_flag = 1'b1;
            if (fill_count >= 64) compress_block();
            push_single(1'b0);
         end
      end else if (rq.op == OP_FINISH) begin
         if (bad_flag) begin
            push_single(1'b1);
            return;
         end
         if (!done_flag) begin
            msg_block[fill_count & 63] = PAD_BYTE;
            fill_count++;
            if (fill_count > 56) begin
               while (fill_count < 64) begin
                  msg_block[fill_count] = 8'h00;
                  fill_count++;
               end
               compress_block();
            end
            while (fill_count < 56) begin
               msg_block[fill_count] = 8'h00;
               fill_count++;
            end
            for (int i = 0; i < 8; i++) msg_block[56+i] = msg_bits[63-8*i -: 8];
            compress_block();
            for (int i = 0; i < 64; i++) msg_block[i] = 8'h00;
            msg_bits = '0;
            done_flag = 1'b1;
         end
         for (int i = 0; i < DigestWords; i++) begin
            r.status = 1'b0;
            r.digest_word = hash_state[i];
            r.word_index = 3'(i);
            r.last = (i == DigestWords - 1);
            digest_queue.push_back(r);
         end
      end else begin
         push_single(1'b1);
      end
   endtask

   // Drive one item and wait for it to be taken, idling at random first.
   task automatic send_item(logic [1:0] op, logic [7:0] data);
      int gap;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 18);
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= '{op: op, data_byte: data};
      do @(posedge clock); while (req_full);
      predict_hasher('{op: op, data_byte: data});
      items_sent++;
   endtask

   // Result side: random stalls, compare each popped item with the oldest prediction.
   int stall_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_pop && !rsp_empty) begin
            if (digest_queue.size() == 0) begin
               $display("%0t: unexpected result %h", $time, rsp_data);
               failed = 1'b1;
            end else begin
               rsp_type exp_r;
               exp_r = digest_queue.pop_front();
               if (rsp_data.status !== exp_r.status)
                  $display("%0t: status expected %0h actual %0h", $time,
                           exp_r.status, rsp_data.status);
               if (rsp_data.digest_word !== exp_r.digest_word)
                  $display("%0t: digest_word expected %h actual %h", $time,
                           exp_r.digest_word, rsp_data.digest_word);
               if (rsp_data.word_index !== exp_r.word_index)
                  $display("%0t: word_index expected %0d actual %0d", $time,
                           exp_r.word_index, rsp_data.word_index);
               if (rsp_data.last !== exp_r.last)
                  $display("%0t: last expected %0h actual %0h", $time,
                           exp_r.last, rsp_data.last);
               if (rsp_data !== exp_r) failed = 1'b1;
            end
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_pop <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 17);
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Watchdog on cycles with no accepted item on either side.
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Directed rows: op, byte, and a typed-in single result where obvious.
   typedef struct {
      logic [1:0] op;
      logic [7:0] data;
      bit         typed;
      logic       status;
   } step_row;

   step_row steps [] = '{
      '{OP_FINISH, 8'h00, 1'b0, 1'b0},   // digest of the empty message after reset
      '{OP_FINISH, 8'h00, 1'b0, 1'b0},   // repeated finish re-emits it
      '{OP_BYTE,   8'hFF, 1'b1, 1'b1},   // byte after finish corrupts
      '{OP_BYTE,   8'h00, 1'b1, 1'b1},   // byte while corrupted
      '{OP_FINISH, 8'h00, 1'b1, 1'b1},   // finish while corrupted
      '{2'd3,      8'hA5, 1'b1, 1'b1},   // unused op code
      '{OP_START,  8'h00, 1'b1, 1'b0},   // start clears corruption
      '{OP_BYTE,   8'h61, 1'b1, 1'b0},
      '{OP_BYTE,   8'h62, 1'b1, 1'b0},
      '{OP_BYTE,   8'h63, 1'b1, 1'b0},
      '{OP_FINISH, 8'h00, 1'b0, 1'b0},   // "abc"
      '{2'd3,      8'h5A, 1'b1, 1'b1},   // unused op after finish changes nothing
      '{OP_FINISH, 8'h00, 1'b0, 1'b0},
      '{OP_START,  8'hFF, 1'b1, 1'b0},
      '{OP_BYTE,   8'h00, 1'b1, 1'b0},
      '{OP_FINISH, 8'h00, 1'b0, 1'b0}
   };

   task automatic send_message(int len);
      send_item(OP_START, 8'($urandom));
      for (int i = 0; i < len; i++) send_item(OP_BYTE, 8'($urandom));
      send_item(OP_FINISH, 8'($urandom));
      if ($urandom_range(0, 3) == 0) send_item(OP_FINISH, 8'h00);
   endtask

   initial begin
      int lens [2] = '{56, 64};
      int pick;
      restart_message();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      foreach (steps[i]) begin
         if (steps[i].typed && digest_queue.size() == 0) begin
            send_item(steps[i].op, steps[i].data);
            if (digest_queue[$].status !== steps[i].status) begin
               $display("%0t: row %0d status expected %0h actual %0h", $time, i,
                        steps[i].status, digest_queue[$].status);
               failed = 1'b1;
            end
         end else begin
            send_item(steps[i].op, steps[i].data);
         end
      end

      // Padding boundaries: two final blocks, and a full block then padding.
      foreach (lens[i]) send_message(lens[i]);

      // Random part: mostly short well-formed messages, some noise.
      while (items_sent < 170) begin
         if (items_sent > 145) quiet_tail = 1'b1;
         pick = $urandom_range(0, 9);
         if (pick < 7) begin
            int len;
            len = $urandom_range(0, 12);
            send_message(len);
         end else begin
            send_item(2'($urandom), 8'($urandom));
         end
      end
      req_push <= 1'b0;

      fork
         wait (digest_queue.size() == 0);
         begin
            repeat (200000) @(posedge clock);
            $display("*** FAILED ***");
            $finish;
         end
      join_any
      disable fork;
      repeat (200) @(posedge clock);
      if (!failed && digest_queue.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
